>>> rtl/lsos_pkg.sv
// ----------------------------------------------------------------------------
// Lidar sector scan package
// Shared widths, register indexes, structs and the angle helper functions.
// ----------------------------------------------------------------------------
package lsos_pkg;

   // default widths of range and count fields
   localparam int RANGE_WIDTH_DEF = 16;
   localparam int COUNT_WIDTH_DEF = 16;

   // raw beam angle, centidegrees, two's complement
   localparam int RAW_ANG_W = 18;
   // normalized angle in half centidegrees, 0..71999
   localparam int ANG_W = 17;
   // signed working width for angle sums before normalization
   localparam int ANGX_W = 20;

   localparam int FULL_TURN   = 72000;
   localparam int SIDE_OFFSET = 9000;
   localparam int MIN_HALF    = 200;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DETECT_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_WIDTH   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_WIDTH    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_WIDTH   = 3'd6;

   typedef struct packed {
      logic        detect_enable;
      logic [15:0] center_cdeg;
      logic [14:0] half_width_cdeg;
      logic [15:0] threshold_mm;
      logic [15:0] front_width_cdeg;
      logic [15:0] left_width_cdeg;
      logic [15:0] right_width_cdeg;
   } cfg_type;

   // sector bounds, both inclusive, normalized half centidegrees
   typedef struct packed {
      logic [ANG_W-1:0] lo;
      logic [ANG_W-1:0] hi;
   } sector_type;

   typedef struct packed {
      sector_type main;
      sector_type front;
      sector_type left;
      sector_type right;
   } bounds_type;

   // reduce a value within four turns either side of zero into one turn
   function automatic logic [ANG_W-1:0] norm_turn(input logic signed [ANGX_W-1:0] a);
      logic signed [ANGX_W-1:0] base;
      base = ANGX_W'(-4 * FULL_TURN);
      for (int k = -3; k <= 3; k++) begin
         if (a >= ANGX_W'(k * FULL_TURN)) begin
            base = ANGX_W'(k * FULL_TURN);
         end
      end
      return ANG_W'(a - base);
   endfunction

   // widen a normalized angle to the signed working width
   function automatic logic signed [ANGX_W-1:0] to_x(input logic [ANG_W-1:0] v);
      return signed'({{(ANGX_W - ANG_W){1'b0}}, v});
   endfunction

   // half width of a side sector: width in centidegrees equals half width in
   // half centidegrees, floored at one degree
   function automatic logic [15:0] side_half(input logic [15:0] w);
      return (w < 16'(MIN_HALF)) ? 16'(MIN_HALF) : w;
   endfunction

   // wrap-aware inclusive sector test
   function automatic logic in_sector(input logic [ANG_W-1:0] n, input sector_type b);
      if (b.lo <= b.hi) begin
         return (n >= b.lo) && (n <= b.hi);
      end
      return (n >= b.lo) || (n <= b.hi);
   endfunction

endpackage

>>> rtl/lsos_geom.sv
// ----------------------------------------------------------------------------
// Sector geometry
// Derives the four sector bounds from the configuration registers.
// ----------------------------------------------------------------------------
module lsos_geom import lsos_pkg::*; (
   input  logic       clock,
   input  cfg_type    cfg,
   // main and front come from the second step behind cfg, left and right from the third
   output bounds_type bounds
);

   // first step: normalized centre and the half widths
   logic [ANG_W-1:0] cn_ff, cn_in;
   logic [15:0]      hm_ff, hm_in;
   logic [15:0]      hf_ff, hf_in;
   logic [15:0]      hl_ff, hl_in;
   logic [15:0]      hr_ff, hr_in;

   // second step: main and front bounds, side centres
   sector_type       main_ff, main_in;
   sector_type       front_ff, front_in;
   logic [ANG_W-1:0] cl_ff, cl_in;
   logic [ANG_W-1:0] cr_ff, cr_in;
   logic [15:0]      hl2_ff, hr2_ff;

   // third step: side bounds
   sector_type       left_ff, left_in;
   sector_type       right_ff, right_in;

   always_comb begin
      cn_in = norm_turn(signed'({3'b000, cfg.center_cdeg, 1'b0}));
      hm_in = {cfg.half_width_cdeg, 1'b0};
      hf_in = side_half(cfg.front_width_cdeg);
      hl_in = side_half(cfg.left_width_cdeg);
      hr_in = side_half(cfg.right_width_cdeg);

      main_in.lo  = norm_turn(to_x(cn_ff) - to_x({1'b0, hm_ff}));
      main_in.hi  = norm_turn(to_x(cn_ff) + to_x({1'b0, hm_ff}));
      front_in.lo = norm_turn(to_x(cn_ff) - to_x({1'b0, hf_ff}));
      front_in.hi = norm_turn(to_x(cn_ff) + to_x({1'b0, hf_ff}));
      cl_in       = norm_turn(to_x(cn_ff) + ANGX_W'(SIDE_OFFSET));
      cr_in       = norm_turn(to_x(cn_ff) - ANGX_W'(SIDE_OFFSET));

      left_in.lo  = norm_turn(to_x(cl_ff) - to_x({1'b0, hl2_ff}));
      left_in.hi  = norm_turn(to_x(cl_ff) + to_x({1'b0, hl2_ff}));
      right_in.lo = norm_turn(to_x(cr_ff) - to_x({1'b0, hr2_ff}));
      right_in.hi = norm_turn(to_x(cr_ff) + to_x({1'b0, hr2_ff}));
   end

   always_ff @(posedge clock) begin
      cn_ff    <= cn_in;
      hm_ff    <= hm_in;
      hf_ff    <= hf_in;
      hl_ff    <= hl_in;
      hr_ff    <= hr_in;
      main_ff  <= main_in;
      front_ff <= front_in;
      cl_ff    <= cl_in;
      cr_ff    <= cr_in;
      hl2_ff   <= hl_ff;
      hr2_ff   <= hr_ff;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign bounds.main  = main_ff;
   assign bounds.front = front_ff;
   assign bounds.left  = left_ff;
   assign bounds.right = right_ff;

endmodule

>>> rtl/lidar_sector_obstacle_scan_top.sv
// ----------------------------------------------------------------------------
// Lidar sector obstacle scan
// Per-scan hit counts, minimum ranges and obstacle flags over four sectors.
// ----------------------------------------------------------------------------
// The block takes one lidar sample per beat on req_ and returns one summary
// beat on rsp_ for every beat that carries req_tlast. A sample counts when
// its range is finite and lies inside the scan's limits; its angle is then
// tested against the main sector, a front sector on the same centre and left
// and right sectors 45 degrees either side. Throughput is one sample per
// clock with no bubbles while the pipe does not stall. A sample passes four
// pipeline registers (input, angle normalization, main/front test, left/right
// test) before it reaches the accumulators; the summary of a scan is registered
// on rsp_ as its last sample leaves the last stage. The rsp_ output register holds a
// finished summary while samples of the next scan keep flowing; the pipe
// stalls only when a second end of scan reaches the accumulators before
// the first summary was taken. The sector bounds come from a three-stage
// registered chain off the configuration registers, timed so that a sample
// beat accepted on the clock edge after the last csr_ write already sees the
// new settings; write csr_ only while no sample is in flight.
// ----------------------------------------------------------------------------
module lidar_sector_obstacle_scan_top import lsos_pkg::*; #(
   parameter  int RANGE_WIDTH = RANGE_WIDTH_DEF,
   parameter  int COUNT_WIDTH = COUNT_WIDTH_DEF,
   localparam int REQ_DATA_W  = ((3 * RANGE_WIDTH + RAW_ANG_W + 7) / 8) * 8,
   localparam int RSP_DATA_W  = ((4 * COUNT_WIDTH + 4 * RANGE_WIDTH + RAW_ANG_W + 2 + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,

   // sample stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // range_mm, scan lower range limit, scan upper range limit, beam_angle_cdeg
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // range_finite
   input  logic                   req_tuser,
   // scan_last
   input  logic                   req_tlast,

   // summary stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // main hits, front hits, left hits, right hits, main_min_mm,
   // main_min_angle_cdeg, front_min_mm, left_min_mm, right_min_mm,
   // main obstacle flag, summary_detected
   output logic [RSP_DATA_W-1:0]  rsp_tdata,

   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NUM_SEC   = 4;
   localparam int SEC_MAIN  = 0;
   localparam int SEC_FRONT = 1;
   localparam int SEC_LEFT  = 2;
   localparam int SEC_RIGHT = 3;

   // request field offsets inside tdata
   localparam int OFF_RANGE = 0;
   localparam int OFF_RMIN  = RANGE_WIDTH;
   localparam int OFF_RMAX  = 2 * RANGE_WIDTH;
   localparam int OFF_ANG   = 3 * RANGE_WIDTH;

   localparam int RSP_FIELD_W = 4 * COUNT_WIDTH + 4 * RANGE_WIDTH + RAW_ANG_W + 2;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   cfg_type    cfg_ff, cfg_in;
   bounds_type bounds;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DETECT_ENABLE: cfg_in.detect_enable    = csr_wdata[0];
            CSR_CENTER:        cfg_in.center_cdeg      = csr_wdata;
            CSR_HALF_WIDTH:    cfg_in.half_width_cdeg  = csr_wdata[14:0];
            CSR_THRESHOLD:     cfg_in.threshold_mm     = csr_wdata;
            CSR_FRONT_WIDTH:   cfg_in.front_width_cdeg = csr_wdata;
            CSR_LEFT_WIDTH:    cfg_in.left_width_cdeg  = csr_wdata;
            CSR_RIGHT_WIDTH:   cfg_in.right_width_cdeg = csr_wdata;
            default:           cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_enable    <= 1'b1;
         cfg_ff.center_cdeg      <= 16'd27000;
         cfg_ff.half_width_cdeg  <= 15'd3000;
         cfg_ff.threshold_mm     <= 16'd2000;
         cfg_ff.front_width_cdeg <= 16'd4000;
         cfg_ff.left_width_cdeg  <= 16'd3500;
         cfg_ff.right_width_cdeg <= 16'd3500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsos_geom u_geom (
      .clock  (clock),
      .cfg    (cfg_ff),
      .bounds (bounds)
   );

   // ------------------------------------------------------------------------
   // sample pipeline
   // ------------------------------------------------------------------------
   // stage 1: input register
   logic                   v1_ff;
   logic [RANGE_WIDTH-1:0] r1_ff, rmin1_ff, rmax1_ff;
   logic [RAW_ANG_W-1:0]   raw1_ff;
   logic                   fin1_ff, last1_ff;

   // stage 2: normalized angle, range qualified
   logic                   v2_ff, keep2_ff, last2_ff;
   logic [ANG_W-1:0]       an2_ff;
   logic [RANGE_WIDTH-1:0] r2_ff;
   logic [RAW_ANG_W-1:0]   raw2_ff;

   // stage 3: main and front tested
   logic                   v3_ff, last3_ff, keep3_ff;
   logic [1:0]             hit3_ff;
   logic [ANG_W-1:0]       an3_ff;
   logic [RANGE_WIDTH-1:0] r3_ff;
   logic [RAW_ANG_W-1:0]   raw3_ff;

   // stage 4: all sectors tested, feeds the accumulators
   logic                   v4_ff, last4_ff;
   logic [NUM_SEC-1:0]     hit4_ff;
   logic [RANGE_WIDTH-1:0] r4_ff;
   logic [RAW_ANG_W-1:0]   raw4_ff;

   logic fire4, take4, take3, take2, take1;

   // stall only when an end of scan meets an occupied output register
   assign fire4 = v4_ff && !(last4_ff && rsp_tvalid && !rsp_tready);
   assign take4 = !v4_ff || fire4;
   assign take3 = !v3_ff || take4;
   assign take2 = !v2_ff || take3;
   assign take1 = !v1_ff || take2;
   assign req_tready = take1;

   logic                   keep2_in;
   logic [ANG_W-1:0]       an2_in;
   logic [1:0]             hit3_in;
   logic [NUM_SEC-1:0]     hit4_in;

   always_comb begin
      keep2_in = cfg_ff.detect_enable && fin1_ff &&
                 (r1_ff >= rmin1_ff) && (r1_ff <= rmax1_ff);
      an2_in   = norm_turn(signed'({{(ANGX_W - RAW_ANG_W - 1){raw1_ff[RAW_ANG_W-1]}},
                                    raw1_ff, 1'b0}));

      hit3_in[0] = keep2_ff && in_sector(an2_ff, bounds.main);
      hit3_in[1] = keep2_ff && in_sector(an2_ff, bounds.front);

      hit4_in[SEC_MAIN]  = hit3_ff[0];
      hit4_in[SEC_FRONT] = hit3_ff[1];
      // a sample without main or front hits may still land in a side sector,
      // so qualify the sides with keep carried beside hit3, not with the hit3 bits
      hit4_in[SEC_LEFT]  = keep3_ff && in_sector(an3_ff, bounds.left);
      hit4_in[SEC_RIGHT] = keep3_ff && in_sector(an3_ff, bounds.right);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (take1) v1_ff <= req_tvalid;
         if (take2) v2_ff <= v1_ff;
         if (take3) v3_ff <= v2_ff;
         if (take4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take1) begin
         r1_ff    <= req_tdata[OFF_RANGE +: RANGE_WIDTH];
         rmin1_ff <= req_tdata[OFF_RMIN +: RANGE_WIDTH];
         rmax1_ff <= req_tdata[OFF_RMAX +: RANGE_WIDTH];
         raw1_ff  <= req_tdata[OFF_ANG +: RAW_ANG_W];
         fin1_ff  <= req_tuser;
         last1_ff <= req_tlast;
      end
      if (take2) begin
         keep2_ff <= keep2_in;
         an2_ff   <= an2_in;
         r2_ff    <= r1_ff;
         raw2_ff  <= raw1_ff;
         last2_ff <= last1_ff;
      end
      if (take3) begin
         hit3_ff  <= hit3_in;
         keep3_ff <= keep2_ff;
         an3_ff   <= an2_ff;
         r3_ff    <= r2_ff;
         raw3_ff  <= raw2_ff;
         last3_ff <= last2_ff;
      end
      if (take4) begin
         hit4_ff  <= hit4_in;
         r4_ff    <= r3_ff;
         raw4_ff  <= raw3_ff;
         last4_ff <= last3_ff;
      end
   end

   // ------------------------------------------------------------------------
   // accumulators
   // ------------------------------------------------------------------------
   logic [COUNT_WIDTH-1:0] cnt_ff [NUM_SEC];
   logic [COUNT_WIDTH-1:0] cnt_in [NUM_SEC];
   logic [RANGE_WIDTH-1:0] min_ff [NUM_SEC];
   logic [RANGE_WIDTH-1:0] min_in [NUM_SEC];
   logic [RAW_ANG_W-1:0]   ang_ff, ang_in;

   always_comb begin
      for (int i = 0; i < NUM_SEC; i++) begin
         // counts saturate; an equal range keeps the earlier minimum
         cnt_in[i] = (hit4_ff[i] && (cnt_ff[i] != '1)) ? cnt_ff[i] + 1'b1 : cnt_ff[i];
         min_in[i] = (hit4_ff[i] && (r4_ff < min_ff[i])) ? r4_ff : min_ff[i];
      end
      ang_in = (hit4_ff[SEC_MAIN] && (r4_ff < min_ff[SEC_MAIN])) ? raw4_ff : ang_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SEC; i++) begin
            cnt_ff[i] <= '0;
            min_ff[i] <= '1;
         end
         ang_ff <= '0;
      end else if (fire4) begin
         if (last4_ff) begin
            // summary taken from the update below; clear for the next scan
            for (int i = 0; i < NUM_SEC; i++) begin
               cnt_ff[i] <= '0;
               min_ff[i] <= '1;
            end
            ang_ff <= '0;
         end else begin
            for (int i = 0; i < NUM_SEC; i++) begin
               cnt_ff[i] <= cnt_in[i];
               min_ff[i] <= min_in[i];
            end
            ang_ff <= ang_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // summary output register
   // ------------------------------------------------------------------------
   logic [COUNT_WIDTH-1:0] res_cnt [NUM_SEC];
   logic [RANGE_WIDTH-1:0] res_min [NUM_SEC];
   logic [RAW_ANG_W-1:0]   res_ang;
   logic                   det_main, det_front;
   logic [RSP_FIELD_W-1:0] rsp_fields;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;

   always_comb begin
      // disabled: report the empty scan
      for (int i = 0; i < NUM_SEC; i++) begin
         res_cnt[i] = cfg_ff.detect_enable ? cnt_in[i] : '0;
         res_min[i] = cfg_ff.detect_enable ? min_in[i] : '1;
      end
      res_ang   = cfg_ff.detect_enable ? ang_in : '0;
      det_main  = (res_cnt[SEC_MAIN] != '0) &&
                  (32'(res_min[SEC_MAIN]) < 32'(cfg_ff.threshold_mm));
      det_front = (res_cnt[SEC_FRONT] != '0) &&
                  (32'(res_min[SEC_FRONT]) < 32'(cfg_ff.threshold_mm));
      rsp_fields = {det_main || det_front, det_main,
                    res_min[SEC_RIGHT], res_min[SEC_LEFT], res_min[SEC_FRONT],
                    res_ang, res_min[SEC_MAIN],
                    res_cnt[SEC_RIGHT], res_cnt[SEC_LEFT], res_cnt[SEC_FRONT],
                    res_cnt[SEC_MAIN]};

      if (fire4 && last4_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire4 && last4_ff) begin
         rsp_data_ff <= RSP_DATA_W'(rsp_fields);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // a summary beat only appears after an end of scan left the accumulators
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire4 && last4_ff))
      else $error("summary beat without end of scan");

   // accumulators start clean after every summary
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (fire4 && last4_ff) |=> (cnt_ff[SEC_MAIN] == '0) && (min_ff[SEC_MAIN] == '1) &&
                              (cnt_ff[SEC_FRONT] == '0) && (ang_ff == '0))
      else $error("accumulators not cleared after end of scan");

   // an empty sector keeps its minimum at all ones
   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[SEC_MAIN] == '0) |-> (min_ff[SEC_MAIN] == '1) && (ang_ff == '0))
      else $error("empty main sector holds a minimum");

   // input back-pressure only with every stage occupied
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v1_ff && v2_ff && v3_ff && v4_ff && rsp_valid_ff)
      else $error("input stalled with room in the pipeline");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lidar sector obstacle scan testbench
// Streams lidar samples into the block under several register settings and
// handshake patterns, predicts every per-scan summary in-house and checks
// each summary beat field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb import lsos_pkg::*; ();

   localparam int REQ_W         = 72;
   localparam int RSP_W         = 152;
   // keep a wide margin over the slowest legal run
   localparam int CYCLE_LIMIT   = 100000;
   // long receiver hold-off that backs the pipe up into req_tready
   localparam int HOLD_CYCLES   = 300;
   // let the pipe, the bounds chain and the accumulators settle
   localparam int SETTLE_CYCLES = 12;
   // index past the register list; writes to it must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   // req_tdata layout, lowest field last
   typedef struct packed {
      logic [5:0]         pad;
      logic signed [17:0] beam_angle;
      logic [15:0]        rng_hi;
      logic [15:0]        rng_lo;
      logic [15:0]        range_mm;
   } sample_data_type;

   typedef struct {
      sample_data_type data;
      logic            finite;
      logic            last;
   } sample_type;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [3:0]  pad;
      logic        summary_detected;
      logic        main_flag;
      logic [15:0] right_min;
      logic [15:0] left_min;
      logic [15:0] front_min;
      logic [17:0] main_min_angle;
      logic [15:0] main_min;
      logic [15:0] right_hits;
      logic [15:0] left_hits;
      logic [15:0] front_hits;
      logic [15:0] main_hits;
   } summary_type;

   // register settings: power-up values and the two corner settings
   localparam cfg_type RESET_CFG = '{detect_enable: 1'b1, center_cdeg: 16'd27000,
      half_width_cdeg: 15'd3000, threshold_mm: 16'd2000, front_width_cdeg: 16'd4000,
      left_width_cdeg: 16'd3500, right_width_cdeg: 16'd3500};
   // centre at zero, main sector a single opposite angle, every range under 65535 flags
   localparam cfg_type WIDE_CFG = '{detect_enable: 1'b1, center_cdeg: 16'd0,
      half_width_cdeg: 15'd18000, threshold_mm: 16'd65535, front_width_cdeg: 16'd100,
      left_width_cdeg: 16'd36000, right_width_cdeg: 16'd36000};
   // centre at the top of the range, zero-width main sector, nothing flags
   localparam cfg_type NARROW_CFG = '{detect_enable: 1'b1, center_cdeg: 16'd35999,
      half_width_cdeg: 15'd0, threshold_mm: 16'd0, front_width_cdeg: 16'd100,
      left_width_cdeg: 16'd100, right_width_cdeg: 16'd100};

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   wire              req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tuser  = 1'b0;
   logic             req_tlast  = 1'b0;
   wire              rsp_tvalid;
   logic             rsp_tready = 1'b0;
   wire  [RSP_W-1:0] rsp_tdata;
   logic             csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor copies of the registers and the running scan
   cfg_type       dut_cfg;
   summary_type   scan_tally;
   summary_type   summaries_due[$];
   sample_type    samples_pending[$];
   sample_type    beat_now;
   idle_mode_type idle_mode  = IDLE_NONE;
   bit            hold_on    = 1'b0;
   int            hold_count = 0;
   int            err_count  = 0;
   int            cycle_count = 0;

   lidar_sector_obstacle_scan_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Sector arithmetic, all in half centidegrees so odd widths halve exactly
   // ---------------------------------------------------------------------
   function automatic int wrap_turn(input int a);
      int r;
      r = a % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      return r;
   endfunction

   // inclusive arc test; an arc whose start passes its end wraps through zero
   function automatic bit in_arc(input int a, input int ctr, input int half);
      int n, lo, hi;
      n  = wrap_turn(a);
      lo = wrap_turn(ctr - half);
      hi = wrap_turn(ctr + half);
      if (lo <= hi) return (n >= lo) && (n <= hi);
      return (n >= lo) || (n <= hi);
   endfunction

   // a full width in centidegrees is the half width in half centidegrees,
   // floored at one degree
   function automatic int side_floor(input logic [15:0] w);
      return (w < 16'(MIN_HALF)) ? MIN_HALF : int'(w);
   endfunction

   function automatic summary_type empty_tally();
      summary_type t;
      t = '0;
      t.main_min  = '1;
      t.front_min = '1;
      t.left_min  = '1;
      t.right_min = '1;
      return t;
   endfunction

   function automatic void bump_sector(inout logic [15:0] count, inout logic [15:0] low,
                                       input logic [15:0] r);
      if (count != 16'hFFFF) count++;
      if (r < low) low = r;
   endfunction

   // fold one accepted sample into the running scan; close the scan on last
   function automatic void accumulate_sample(input sample_type s);
      int ang2, ctr2;
      summary_type done;
      if (dut_cfg.detect_enable && s.finite && s.data.range_mm >= s.data.rng_lo &&
          s.data.range_mm <= s.data.rng_hi) begin
         ang2 = 2 * int'($signed(s.data.beam_angle));
         ctr2 = 2 * int'(dut_cfg.center_cdeg);
         if (in_arc(ang2, ctr2, 2 * int'(dut_cfg.half_width_cdeg))) begin
            if (scan_tally.main_hits != 16'hFFFF) scan_tally.main_hits++;
            // strict compare: a tie keeps the angle of the first minimum
            if (s.data.range_mm < scan_tally.main_min) begin
               scan_tally.main_min       = s.data.range_mm;
               scan_tally.main_min_angle = s.data.beam_angle;
            end
         end
         if (in_arc(ang2, ctr2, side_floor(dut_cfg.front_width_cdeg)))
            bump_sector(scan_tally.front_hits, scan_tally.front_min, s.data.range_mm);
         if (in_arc(ang2, ctr2 + SIDE_OFFSET, side_floor(dut_cfg.left_width_cdeg)))
            bump_sector(scan_tally.left_hits, scan_tally.left_min, s.data.range_mm);
         if (in_arc(ang2, ctr2 - SIDE_OFFSET, side_floor(dut_cfg.right_width_cdeg)))
            bump_sector(scan_tally.right_hits, scan_tally.right_min, s.data.range_mm);
      end
      if (s.last) begin
         done = dut_cfg.detect_enable ? scan_tally : empty_tally();
         done.main_flag        = (done.main_hits != 0) &&
                                 (done.main_min < dut_cfg.threshold_mm);
         done.summary_detected = done.main_flag ||
                                 ((done.front_hits != 0) &&
                                  (done.front_min < dut_cfg.threshold_mm));
         summaries_due.push_back(done);
         scan_tally = empty_tally();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Mismatch reporting and summary checks
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      err_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic check_summary(input summary_type got);
      summary_type want;
      if (summaries_due.size() == 0) begin
         report_mismatch("summary beat with no scan outstanding");
      end else begin
         want = summaries_due.pop_front();
         check_field("main_hits",   32'(got.main_hits),   32'(want.main_hits));
         check_field("front_hits",  32'(got.front_hits),  32'(want.front_hits));
         check_field("left_hits",   32'(got.left_hits),   32'(want.left_hits));
         check_field("right_hits",  32'(got.right_hits),  32'(want.right_hits));
         check_field("main_min_mm", 32'(got.main_min),    32'(want.main_min));
         check_field("main_min_angle_cdeg", 32'(got.main_min_angle),
                     32'(want.main_min_angle));
         check_field("front_min_mm", 32'(got.front_min),  32'(want.front_min));
         check_field("left_min_mm",  32'(got.left_min),   32'(want.left_min));
         check_field("right_min_mm", 32'(got.right_min),  32'(want.right_min));
         check_field("main_flag",    32'(got.main_flag),  32'(want.main_flag));
         check_field("summary_detected", 32'(got.summary_detected),
                     32'(want.summary_detected));
      end
   endtask

   // ---------------------------------------------------------------------
   // Handshake pacing
   // ---------------------------------------------------------------------
   function automatic bit sender_pauses();
      case (idle_mode)
         IDLE_SEND: return $urandom_range(0, 99) < 49;
         IDLE_BOTH: return $urandom_range(0, 99) < 34;
         default:   return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_pauses();
      case (idle_mode)
         IDLE_RECV: return $urandom_range(0, 99) < 49;
         IDLE_BOTH: return $urandom_range(0, 99) < 34;
         default:   return 1'b0;
      endcase
   endfunction

   // Driver: predict on each accepted beat, then offer the next one. Valid is
   // assigned once per edge so a held beat never drops for a step.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) accumulate_sample(beat_now);
         if (!req_tvalid || req_tready) begin
            if (samples_pending.size() > 0 && !sender_pauses()) begin
               beat_now = samples_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= beat_now.data;
               req_tuser  <= beat_now.finite;
               req_tlast  <= beat_now.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: one long hold-off when asked, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_on && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !receiver_pauses();
      end
   end

   // Monitor: check every summary beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_summary(summary_type'(rsp_tdata));
   end

   // Watchdog: a hung handshake or a missing summary ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void push_sample(input int range_mm, input bit finite, input int rmin,
                                       input int rmax, input int angle, input bit last);
      sample_type s;
      s.data            = '0;
      s.data.range_mm   = 16'(range_mm);
      s.data.rng_lo     = 16'(rmin);
      s.data.rng_hi     = 16'(rmax);
      s.data.beam_angle = 18'(angle);
      s.finite          = finite;
      s.last            = last;
      samples_pending.push_back(s);
   endfunction

   // bring an angle back into the legal raw range by whole turns
   function automatic int fold_angle(input int a);
      while (a > 71999) a -= 36000;
      while (a < -36000) a += 36000;
      return a;
   endfunction

   // mostly angles on or near a sector boundary, with a turn added or taken
   function automatic int pick_angle();
      int ctr, span, offs;
      ctr = int'(dut_cfg.center_cdeg);
      case ($urandom_range(0, 4))
         0: return fold_angle(int'($urandom_range(0, 107999)) - 36000);
         1: span = int'(dut_cfg.half_width_cdeg);
         2: span = side_floor(dut_cfg.front_width_cdeg) / 2;
         3: begin
            ctr += 4500;
            span = side_floor(dut_cfg.left_width_cdeg) / 2;
         end
         default: begin
            ctr -= 4500;
            span = side_floor(dut_cfg.right_width_cdeg) / 2;
         end
      endcase
      case ($urandom_range(0, 2))
         0:       offs = span + int'($urandom_range(0, 4)) - 2;
         1:       offs = -span + int'($urandom_range(0, 4)) - 2;
         default: offs = int'($urandom_range(0, 2 * span)) - span;
      endcase
      return fold_angle(ctr + offs + 36000 * (int'($urandom_range(0, 2)) - 1));
   endfunction

   function automatic void push_random(input bit last);
      int r, lo, hi;
      bit fin;
      lo = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                       : int'($urandom_range(0, 255));
      hi = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                       : int'($urandom_range(30000, 65535));
      case ($urandom_range(0, 3))
         0:       r = int'($urandom_range(0, 65535));
         1:       r = lo + int'($urandom_range(0, 2));
         2:       r = hi - int'($urandom_range(0, 2));
         // coarse steps give plenty of equal ranges
         default: r = 200 * int'($urandom_range(1, 15));
      endcase
      fin = ($urandom_range(0, 11) != 0);
      push_sample(r, fin, lo, hi, pick_angle(), last);
   endfunction

   // queue whole scans of random length, each closed by a last beat
   function automatic void queue_scans(input int n_items, input int max_len);
      int left_over, len;
      left_over = n_items;
      while (left_over > 0) begin
         len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 40))
                                           : int'($urandom_range(1, max_len));
         if (len > left_over) len = left_over;
         for (int i = 0; i < len; i++) push_random(i == len - 1);
         left_over -= len;
      end
   endfunction

   function automatic int extreme_or_any(input int lo, input int hi);
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return hi;
         default: return int'($urandom_range(lo, hi));
      endcase
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.detect_enable    = 1'b1;
      c.center_cdeg      = 16'(extreme_or_any(0, 35999));
      c.half_width_cdeg  = 15'(extreme_or_any(0, 18000));
      c.threshold_mm     = 16'(extreme_or_any(0, 65535));
      c.front_width_cdeg = 16'(extreme_or_any(100, 36000));
      c.left_width_cdeg  = 16'(extreme_or_any(100, 36000));
      c.right_width_cdeg = 16'(extreme_or_any(100, 36000));
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Register writes and phase boundaries
   // ---------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_DETECT_ENABLE: dut_cfg.detect_enable    = value[0];
         CSR_CENTER:        dut_cfg.center_cdeg      = value;
         CSR_HALF_WIDTH:    dut_cfg.half_width_cdeg  = value[14:0];
         CSR_THRESHOLD:     dut_cfg.threshold_mm     = value;
         CSR_FRONT_WIDTH:   dut_cfg.front_width_cdeg = value;
         CSR_LEFT_WIDTH:    dut_cfg.left_width_cdeg  = value;
         CSR_RIGHT_WIDTH:   dut_cfg.right_width_cdeg = value;
         default: ;
      endcase
   endtask

   // write every register, poke the unused index, then let the bounds settle
   task automatic load_config(input cfg_type c);
      write_reg(CSR_UNUSED, 16'($urandom_range(0, 65535)));
      write_reg(CSR_DETECT_ENABLE, 16'(c.detect_enable));
      write_reg(CSR_CENTER, c.center_cdeg);
      write_reg(CSR_HALF_WIDTH, 16'(c.half_width_cdeg));
      write_reg(CSR_THRESHOLD, c.threshold_mm);
      write_reg(CSR_FRONT_WIDTH, c.front_width_cdeg);
      write_reg(CSR_LEFT_WIDTH, c.left_width_cdeg);
      write_reg(CSR_RIGHT_WIDTH, c.right_width_cdeg);
      @(posedge clock);
      csr_we <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // hold until every queued beat went in and every summary came out
   task automatic wait_idle();
      while (samples_pending.size() != 0 || req_tvalid || summaries_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      cfg_type c;
      dut_cfg    = RESET_CFG;
      scan_tally = empty_tally();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // power-up settings: main 240..300 deg, front 250..290, left and right
      // 45 deg either side
      push_sample(500, 1, 0, 65535, 63000, 0);   // one turn up, main and front
      push_sample(500, 1, 0, 65535, 26000, 0);   // equal range keeps first angle
      push_sample(65535, 1, 0, 65535, -9000, 0); // negative raw angle, top range
      push_sample(100, 0, 0, 65535, 27000, 0);   // not finite: drop
      push_sample(50, 1, 60, 65535, 27000, 0);   // below scan minimum: drop
      push_sample(7000, 1, 0, 6999, 27000, 0);   // above scan maximum: drop
      push_sample(1200, 1, 0, 65535, 24000, 0);  // main start, inclusive
      push_sample(1300, 1, 0, 65535, 30000, 0);  // main end, inclusive
      push_sample(1400, 1, 0, 65535, 23999, 0);  // just outside main
      push_sample(1500, 1, 0, 65535, 30001, 0);  // just outside main
      push_sample(800, 1, 0, 65535, -36000, 0);  // lowest raw angle
      push_sample(900, 1, 0, 65535, 71999, 0);   // highest raw angle
      push_sample(0, 0, 65535, 0, 0, 1);         // dropped sample still ends scan
      push_sample(3000, 1, 0, 65535, 27000, 1);  // near miss on the threshold
      push_sample(0, 0, 0, 0, 0, 1);             // empty scan
      wait_idle();

      // half width of 180 deg: only the opposite angle matches
      load_config(WIDE_CFG);
      push_sample(10, 1, 0, 65535, 18000, 0);
      push_sample(20, 1, 0, 65535, -100, 0);     // front floor of one degree
      push_sample(30, 1, 0, 65535, 100, 0);
      push_sample(40, 1, 0, 65535, 101, 0);
      push_sample(50, 1, 0, 65535, 22500, 0);    // opposite the left centre
      push_sample(60, 1, 0, 65535, 13500, 1);    // opposite the right centre
      wait_idle();

      // zero-width main sector at the top of the centre range
      load_config(NARROW_CFG);
      push_sample(65535, 1, 0, 65535, -1, 0);
      push_sample(70, 1, 0, 65535, 35998, 1);
      wait_idle();

      // detection off: samples ignored, scan reports empty
      c = RESET_CFG;
      c.detect_enable = 1'b0;
      load_config(c);
      push_sample(100, 1, 0, 65535, 27000, 0);
      push_sample(100, 1, 0, 65535, 27000, 1);
      wait_idle();

      // random scans across settings and handshake patterns
      for (int p = 0; p < 8; p++) begin
         c = random_config();
         if (p == 1) c = NARROW_CFG;
         if (p == 2) c = WIDE_CFG;
         if (p == 5) c.detect_enable = 1'b0;
         load_config(c);
         idle_mode = idle_mode_type'(p % 4);
         queue_scans(210, 12);
         wait_idle();
      end

      // back-pressure: short scans at full rate against a stalled receiver
      idle_mode = IDLE_NONE;
      load_config(random_config());
      hold_on = 1'b1;
      queue_scans(150, 3);
      wait_idle();
      hold_on = 1'b0;

      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
